>>> design/contiguous_page_allocator_core_macros.svh
// Assertion macros for the checker file of the page allocator.
`ifndef CONTIGUOUS_PAGE_ALLOCATOR_CORE_MACROS_SVH
`define CONTIGUOUS_PAGE_ALLOCATOR_CORE_MACROS_SVH

// The consequent must hold in the cycle after the antecedent.
`define CPA_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define CPA_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

>>> design/cpa_pkg.sv
package cpa_pkg;

   localparam int unsigned PAGES      = 65536;
   localparam int unsigned COUNT_W    = 17;
   localparam int unsigned ADDR_W     = 28;
   localparam int unsigned PAGE_SHIFT = 12;
   localparam int unsigned STATUS_W   = 3;
   localparam int unsigned CSR_IDX_W  = 2;

   // Pages that a byte address can reach, and the deepest page map that is ever used.
   localparam int unsigned ADDR_PAGES = 1 << (ADDR_W - PAGE_SHIFT);
   localparam int unsigned LIMIT_MAX  = (PAGES < ADDR_PAGES) ? PAGES : ADDR_PAGES;
   localparam int unsigned MAP_DEPTH  = LIMIT_MAX;
   localparam int unsigned MAP_W      = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;

   localparam logic [COUNT_W-1:0] TOTAL_PAGES_RESET    = COUNT_W'(25600);
   localparam logic [COUNT_W-1:0] RESERVED_PAGES_RESET = COUNT_W'(5 * 1024);

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_TOTAL_PAGES    = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_RESERVED_PAGES = CSR_IDX_W'(1);

   localparam logic [STATUS_W-1:0] ST_OK           = STATUS_W'(0);
   localparam logic [STATUS_W-1:0] ST_NO_RUN       = STATUS_W'(1);
   localparam logic [STATUS_W-1:0] ST_MISALIGNED   = STATUS_W'(2);
   localparam logic [STATUS_W-1:0] ST_RESERVED     = STATUS_W'(3);
   localparam logic [STATUS_W-1:0] ST_ALREADY_FREE = STATUS_W'(4);
   localparam logic [STATUS_W-1:0] ST_BAD_RANGE    = STATUS_W'(5);

   typedef struct packed {
      logic               cmd;
      logic [COUNT_W-1:0] page_count;
      logic [ADDR_W-1:0]  address;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0]   page_address;
      logic [STATUS_W-1:0] status;
   } rsp_type;

endpackage

>>> design/cpa_page_map.sv
module cpa_page_map
   import cpa_pkg::*;
(
   input  logic             clock,
   input  logic [MAP_W-1:0] rd_addr,
   output logic             rd_data,
   input  logic             wr_en,
   input  logic [MAP_W-1:0] wr_addr,
   input  logic             wr_data
);

   logic used_mem [MAP_DEPTH];
   logic rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         used_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= used_mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/contiguous_page_allocator_core.sv
// First-fit contiguous page allocator over a one-bit-per-page used map held in a memory
// whose read and write ports share one address. After reset the block sweeps all LIMIT_MAX
// (65536) pages of the map clear, one page per cycle, and holds req_stall high meanwhile;
// configuration writes are taken at any time. An allocate scans upward from reserved_pages,
// reading each page and then updating the run count, until a run of page_count free pages
// is found or the page limit is reached, then marks the run page by page. A free checks its
// address and range during the acceptance cycle, reads each page of the run in turn, then
// clears the run page by page. A request rejected at acceptance goes straight to loading its
// result. One request is in flight at a time; a finished result waits in an output register,
// and the next request is accepted while it waits.
module contiguous_page_allocator_core
   import cpa_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [COUNT_W-1:0]   csr_data
);

   typedef enum logic [3:0] {
      CLEAR,
      IDLE,
      ALLOC_RD,
      ALLOC_EV,
      MARK,
      FREE_RD,
      FREE_EV,
      UNMARK,
      FINISH
   } state_type;

   state_type           state_ff, state_in;
   logic [COUNT_W-1:0]  total_ff, total_in;
   logic [COUNT_W-1:0]  reserved_ff, reserved_in;
   logic [COUNT_W-1:0]  cursor_ff, cursor_in;
   logic [COUNT_W-1:0]  run_ff, run_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic [COUNT_W-1:0]  lim_ff, lim_in;
   logic [COUNT_W-1:0]  first_ff, first_in;
   logic [COUNT_W-1:0]  last_ff, last_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic                cmd_ff, cmd_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff, rsp_data_in;

   logic                map_rd_data;
   logic                map_wr_en;
   logic                map_wr_data;

   logic [COUNT_W-1:0]  limit_now;
   logic [COUNT_W-1:0]  req_first;
   logic [COUNT_W-1:0]  cursor_inc;
   logic [COUNT_W-1:0]  run_next;
   logic                req_fire;
   logic                csr_fire;

   cpa_page_map u_page_map (
      .clock   (clock),
      .rd_addr (cursor_ff[MAP_W-1:0]),
      .rd_data (map_rd_data),
      .wr_en   (map_wr_en),
      .wr_addr (cursor_ff[MAP_W-1:0]),
      .wr_data (map_wr_data)
   );

   assign req_stall   = (state_ff != IDLE);
   assign req_fire    = req_valid && !req_stall;
   assign csr_ready   = 1'b1;
   assign csr_fire    = csr_valid && csr_ready;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_data    = rsp_data_ff;
   assign map_wr_en   = (state_ff == CLEAR) || (state_ff == MARK) || (state_ff == UNMARK);
   assign map_wr_data = (state_ff == MARK);

   assign limit_now  = (total_ff > COUNT_W'(LIMIT_MAX)) ? COUNT_W'(LIMIT_MAX) : total_ff;
   assign req_first  = COUNT_W'(req_data.address[ADDR_W-1:PAGE_SHIFT]);
   assign cursor_inc = cursor_ff + COUNT_W'(1);
   assign run_next   = map_rd_data ? '0 : run_ff + COUNT_W'(1);

   always_comb begin
      state_in     = state_ff;
      total_in     = total_ff;
      reserved_in  = reserved_ff;
      cursor_in    = cursor_ff;
      run_in       = run_ff;
      count_in     = count_ff;
      lim_in       = lim_ff;
      first_in     = first_ff;
      last_in      = last_ff;
      status_in    = status_ff;
      cmd_in       = cmd_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;

      if (csr_fire) begin
         unique case (csr_index)
            CSR_TOTAL_PAGES:    total_in    = csr_data;
            CSR_RESERVED_PAGES: reserved_in = csr_data;
            default: ;
         endcase
      end

      unique case (state_ff)
         CLEAR: begin
            cursor_in = cursor_inc;
            if (cursor_ff == COUNT_W'(MAP_DEPTH - 1)) begin
               state_in = IDLE;
            end
         end
         IDLE: begin
            if (req_fire) begin
               cmd_in   = req_data.cmd;
               count_in = req_data.page_count;
               lim_in   = limit_now;
               run_in   = '0;
               state_in = FINISH;
               if (req_data.cmd == CMD_ALLOC) begin
                  cursor_in = reserved_ff;
                  if (req_data.page_count == '0) begin
                     status_in = ST_BAD_RANGE;
                  end else if (reserved_ff >= limit_now) begin
                     status_in = ST_NO_RUN;
                  end else begin
                     state_in = ALLOC_RD;
                  end
               end else begin
                  cursor_in = req_first;
                  first_in  = req_first;
                  last_in   = req_first + req_data.page_count - COUNT_W'(1);
                  if (req_data.address[PAGE_SHIFT-1:0] != '0) begin
                     status_in = ST_MISALIGNED;
                  end else if (req_first < reserved_ff) begin
                     status_in = ST_RESERVED;
                  end else if (req_data.page_count == '0 || req_first >= limit_now ||
                               req_data.page_count > limit_now - req_first) begin
                     status_in = ST_BAD_RANGE;
                  end else begin
                     state_in = FREE_RD;
                  end
               end
            end
         end
         ALLOC_RD: begin
            state_in = ALLOC_EV;
         end
         ALLOC_EV: begin
            run_in = run_next;
            if (run_next == count_ff) begin
               // The run ends at the current page; go back to its first page and mark it.
               first_in  = cursor_inc - count_ff;
               cursor_in = cursor_inc - count_ff;
               last_in   = cursor_ff;
               state_in  = MARK;
            end else if (cursor_inc >= lim_ff) begin
               status_in = ST_NO_RUN;
               state_in  = FINISH;
            end else begin
               cursor_in = cursor_inc;
               state_in  = ALLOC_RD;
            end
         end
         MARK: begin
            cursor_in = cursor_inc;
            if (cursor_ff == last_ff) begin
               status_in = ST_OK;
               state_in  = FINISH;
            end
         end
         FREE_RD: begin
            state_in = FREE_EV;
         end
         FREE_EV: begin
            if (!map_rd_data) begin
               status_in = ST_ALREADY_FREE;
               state_in  = FINISH;
            end else if (cursor_ff == last_ff) begin
               cursor_in = first_ff;
               state_in  = UNMARK;
            end else begin
               cursor_in = cursor_inc;
               state_in  = FREE_RD;
            end
         end
         UNMARK: begin
            cursor_in = cursor_inc;
            if (cursor_ff == last_ff) begin
               status_in = ST_OK;
               state_in  = FINISH;
            end
         end
         FINISH: begin
            // The output register is free once its last transfer has completed.
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in        = 1'b1;
               rsp_data_in.status  = status_ff;
               rsp_data_in.page_address = '0;
               if (cmd_ff == CMD_ALLOC && status_ff == ST_OK) begin
                  rsp_data_in.page_address =
                     {first_ff[ADDR_W-PAGE_SHIFT-1:0], PAGE_SHIFT'(0)};
               end
               state_in = IDLE;
            end
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CLEAR;
         total_ff     <= TOTAL_PAGES_RESET;
         reserved_ff  <= RESERVED_PAGES_RESET;
         cursor_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         reserved_ff  <= reserved_in;
         cursor_ff    <= cursor_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      run_ff      <= run_in;
      count_ff    <= count_in;
      lim_ff      <= lim_in;
      first_ff    <= first_in;
      last_ff     <= last_in;
      status_ff   <= status_in;
      cmd_ff      <= cmd_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

>>> design/cpa_checker.sv
`include "contiguous_page_allocator_core_macros.svh"

module cpa_checker
   import cpa_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // An accepted request keeps req_stall high after its transfer.
   `CPA_ASSERT_NEXT(a_busy_after_req, req_valid && !req_stall, req_stall, "accepted request did not raise stall")

   `CPA_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "stalled result changed")

   `CPA_ASSERT_SAME(a_err_addr_zero, rsp_valid && rsp_data.status != ST_OK, rsp_data.page_address == '0, "error result carries an address")

   `CPA_ASSERT_SAME(a_rsp_well_formed, rsp_valid, rsp_data.page_address[PAGE_SHIFT-1:0] == '0 && rsp_data.status <= ST_BAD_RANGE, "result address unaligned or status unknown")

endmodule

bind contiguous_page_allocator_core cpa_checker u_cpa_checker (.*);

>>> sim/testbench.sv
`timescale 1ns / 100ps

module testbench
   import cpa_pkg::*;
;

   localparam int unsigned CYCLE_LIMIT = 3_000_000;
   localparam int unsigned MAX_COUNT   = (1 << COUNT_W) - 1;

   // Scoreboard: its own copy of the used-page map and the two registers, and a FIFO
   // of the results that the accepted requests must produce.
   class page_map_scoreboard;
      bit                 used [LIMIT_MAX];
      logic [COUNT_W-1:0] total_pages    = TOTAL_PAGES_RESET;
      logic [COUNT_W-1:0] reserved_pages = RESERVED_PAGES_RESET;
      rsp_type            pending [$];
      // Runs known to be held, so that the stimulus can give pages back properly.
      int unsigned        live_first [$];
      int unsigned        live_count [$];
      int                 errors     = 0;
      int                 allocs_ok  = 0;
      int                 frees_ok   = 0;
      int                 rejects    = 0;
      int                 checked    = 0;

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [COUNT_W-1:0] value);
         if (idx == CSR_TOTAL_PAGES) begin
            total_pages = value;
         end else if (idx == CSR_RESERVED_PAGES) begin
            reserved_pages = value;
         end
      endfunction

      function int unsigned page_limit();
         int unsigned lim;
         lim = total_pages;
         if (lim > LIMIT_MAX) begin
            lim = LIMIT_MAX;
         end
         return lim;
      endfunction

      // First-fit search upward from the reserved boundary; marks the run on success.
      function logic [STATUS_W-1:0] claim_run(int unsigned count, output int unsigned first);
         int unsigned lim;
         int unsigned run;
         lim   = page_limit();
         run   = 0;
         first = 0;
         if (count == 0) begin
            return ST_BAD_RANGE;
         end
         for (int unsigned i = reserved_pages; i < lim; i++) begin
            if (used[i]) begin
               run = 0;
            end else begin
               run++;
            end
            if (run == count) begin
               first = i + 1 - count;
               for (int unsigned k = first; k <= i; k++) begin
                  used[k] = 1'b1;
               end
               return ST_OK;
            end
         end
         return ST_NO_RUN;
      endfunction

      function logic [STATUS_W-1:0] release_run(logic [ADDR_W-1:0] addr, int unsigned count);
         int unsigned lim;
         int unsigned first;
         lim = page_limit();
         if (addr[PAGE_SHIFT-1:0] != '0) begin
            return ST_MISALIGNED;
         end
         first = addr >> PAGE_SHIFT;
         if (first < reserved_pages) begin
            return ST_RESERVED;
         end
         if (count == 0 || first >= lim || count > lim - first) begin
            return ST_BAD_RANGE;
         end
         for (int unsigned k = 0; k < count; k++) begin
            if (!used[first + k]) begin
               return ST_ALREADY_FREE;
            end
         end
         for (int unsigned k = 0; k < count; k++) begin
            used[first + k] = 1'b0;
         end
         return ST_OK;
      endfunction

      function void note_request(req_type r);
         rsp_type     exp;
         int unsigned first;
         exp = '0;
         if (r.cmd == CMD_ALLOC) begin
            exp.status = claim_run(r.page_count, first);
            if (exp.status == ST_OK) begin
               exp.page_address = ADDR_W'(first << PAGE_SHIFT);
               live_first.push_back(first);
               live_count.push_back(r.page_count);
               allocs_ok++;
            end
         end else begin
            exp.status = release_run(r.address, r.page_count);
            if (exp.status == ST_OK) begin
               frees_ok++;
            end
         end
         if (exp.status != ST_OK) begin
            rejects++;
         end
         pending.push_back(exp);
      endfunction

      function void check_result(rsp_type got);
         rsp_type exp;
         if (pending.size() == 0) begin
            errors++;
            $error("rsp_data: result %h with no request outstanding", got);
            return;
         end
         exp = pending.pop_front();
         checked++;
         if (got.page_address !== exp.page_address) begin
            errors++;
            $error("page_address: expected %h, actual %h", exp.page_address, got.page_address);
         end
         if (got.status !== exp.status) begin
            errors++;
            $error("status: expected %0d, actual %0d", exp.status, got.status);
         end
      endfunction
   endclass

   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic                 req_valid  = 1'b0;
   logic                 req_stall;
   req_type              req_data   = '0;
   logic                 rsp_valid;
   logic                 rsp_stall  = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_valid  = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index  = '0;
   logic [COUNT_W-1:0]   csr_data   = '0;

   page_map_scoreboard sb = new();
   int unsigned        req_idle_pct  = 0;
   int unsigned        rsp_stall_pct = 0;
   int unsigned        cycles        = 0;
   int                 map_settings  = 0;

   contiguous_page_allocator_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_result(rsp_data);
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles == CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   function automatic logic [ADDR_W-1:0] page_addr(int unsigned page);
      return ADDR_W'(page << PAGE_SHIFT);
   endfunction

   function automatic req_type make_req(logic cmd, int unsigned count, logic [ADDR_W-1:0] addr);
      req_type r;
      r.cmd        = cmd;
      r.page_count = COUNT_W'(count);
      r.address    = addr;
      return r;
   endfunction

   // Called at a falling edge; returns at the falling edge after the transfer, with
   // valid still high so that a following request can go out back to back.
   task automatic send(req_type item);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall !== 1'b0);
      sb.note_request(item);
      @(negedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, int unsigned value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= COUNT_W'(value);
      do @(posedge clock); while (csr_ready !== 1'b1);
      sb.write_reg(idx, COUNT_W'(value));
      @(negedge clock);
   endtask

   // Registers change only once every outstanding result has come back.
   task automatic program_map(int unsigned total, int unsigned reserved);
      req_valid <= 1'b0;
      while (sb.pending.size() != 0) begin
         @(negedge clock);
      end
      repeat (4) @(negedge clock);
      write_csr(CSR_TOTAL_PAGES, total);
      write_csr(CSR_RESERVED_PAGES, reserved);
      csr_valid <= 1'b0;
      sb.live_first.delete();
      sb.live_count.delete();
      map_settings++;
   endtask

   // Mostly proper allocate and release traffic, with some malformed releases and zero or oversized allocates mixed in.
   function automatic req_type random_request();
      req_type     r;
      int unsigned pick;
      int unsigned sub;
      int unsigned j;
      int unsigned first;
      int unsigned count;
      int unsigned part;
      int unsigned lo;
      int unsigned hi;
      r.cmd        = CMD_ALLOC;
      r.address    = ADDR_W'($urandom());
      r.page_count = COUNT_W'($urandom_range(1, 8));
      pick = $urandom_range(99);
      if (pick >= 48 && pick < 83 && sb.live_first.size() != 0) begin
         j     = $urandom_range(sb.live_first.size() - 1);
         first = sb.live_first[j];
         count = sb.live_count[j];
         sb.live_first.delete(j);
         sb.live_count.delete(j);
         part = count;
         // Sometimes give back only the front of a run and keep the rest on the list.
         if (count > 1 && $urandom_range(4) == 0) begin
            part = $urandom_range(1, count - 1);
            sb.live_first.push_back(first + part);
            sb.live_count.push_back(count - part);
         end
         r.cmd        = CMD_FREE;
         r.address    = page_addr(first);
         r.page_count = COUNT_W'(part);
      end else if (pick >= 83) begin
         r.cmd = CMD_FREE;
         if ($urandom_range(1) == 0) begin
            lo = (sb.reserved_pages >= 2) ? sb.reserved_pages - 2 : 0;
            hi = sb.page_limit() + 2;
            if (hi > LIMIT_MAX - 1) begin
               hi = LIMIT_MAX - 1;
            end
            if (lo > LIMIT_MAX - 1) begin
               lo = LIMIT_MAX - 1;
            end
            r.address    = page_addr($urandom_range(lo, hi));
            r.page_count = COUNT_W'($urandom_range(0, 6));
            if ($urandom_range(3) == 0) begin
               r.address[PAGE_SHIFT-1:0] = PAGE_SHIFT'($urandom_range(1, 4095));
            end
         end else begin
            r.page_count = COUNT_W'($urandom());
         end
      end else begin
         sub = $urandom_range(99);
         if (sub < 8) begin
            r.page_count = '0;
         end else if (sub < 11) begin
            r.page_count = COUNT_W'($urandom());
         end else if (sub < 20) begin
            r.page_count = COUNT_W'($urandom_range(9, 40));
         end
      end
      return r;
   endfunction

   initial begin
      int unsigned width;
      int unsigned kind;
      int unsigned total;
      int unsigned reserved;

      req_idle_pct  = 21;
      rsp_stall_pct = 70;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset settings: zero count, first fit around a hole, every release error.
      send(make_req(CMD_ALLOC, 0, '0));
      send(make_req(CMD_ALLOC, 1, '1));
      send(make_req(CMD_ALLOC, 3, '0));
      send(make_req(CMD_FREE, 1, page_addr(5120)));
      send(make_req(CMD_ALLOC, 2, '0));
      send(make_req(CMD_ALLOC, 1, '0));
      send(make_req(CMD_FREE, 1, '1));
      send(make_req(CMD_FREE, 1, page_addr(5119)));
      send(make_req(CMD_FREE, 0, page_addr(5121)));
      send(make_req(CMD_FREE, 1, page_addr(25600)));
      send(make_req(CMD_FREE, 2, page_addr(25599)));
      send(make_req(CMD_FREE, MAX_COUNT, page_addr(LIMIT_MAX - 1)));
      send(make_req(CMD_FREE, 1, page_addr(6000)));
      send(make_req(CMD_FREE, 5, page_addr(5121)));
      send(make_req(CMD_ALLOC, MAX_COUNT, '0));

      // No pages present at all.
      program_map(0, 5120);
      send(make_req(CMD_ALLOC, 1, '0));
      send(make_req(CMD_FREE, 1, page_addr(5120)));

      // Only the topmost page is usable.
      program_map(LIMIT_MAX, LIMIT_MAX - 1);
      send(make_req(CMD_ALLOC, 1, '0));
      send(make_req(CMD_ALLOC, 1, '0));
      send(make_req(CMD_FREE, 2, page_addr(LIMIT_MAX - 1)));
      send(make_req(CMD_FREE, 1, page_addr(LIMIT_MAX - 1)));

      // Nothing reserved, then everything reserved.
      program_map(LIMIT_MAX, 0);
      send(make_req(CMD_ALLOC, 1, '0));
      send(make_req(CMD_FREE, 1, page_addr(0)));
      program_map(LIMIT_MAX, LIMIT_MAX);
      send(make_req(CMD_ALLOC, 1, '0));
      send(make_req(CMD_FREE, 1, page_addr(LIMIT_MAX - 1)));

      for (int mode = 0; mode < 3; mode++) begin
         req_idle_pct  = (mode == 0) ? 21 : (mode == 1) ? 70 : 0;
         rsp_stall_pct = (mode == 0) ? 70 : (mode == 1) ? 21 : 0;
         for (int w = 0; w < 4; w++) begin
            // Narrow page windows keep every search short.
            width = $urandom_range(16, 96);
            kind  = $urandom_range(9);
            if (kind == 0) begin
               total    = LIMIT_MAX;
               reserved = LIMIT_MAX - width;
            end else if (kind == 1) begin
               total    = $urandom_range(0, 65000);
               reserved = total + $urandom_range(1, 500);
            end else begin
               reserved = $urandom_range(0, LIMIT_MAX - width);
               total    = reserved + width;
            end
            program_map(total, reserved);
            for (int n = 0; n < 54; n++) begin
               send(random_request());
            end
         end
      end

      req_valid <= 1'b0;
      while (sb.pending.size() != 0) begin
         @(posedge clock);
      end
      repeat (32) @(posedge clock);

      $display("Checked %0d results over %0d register settings.", sb.checked, map_settings);
      $display("Runs allocated %0d, runs released %0d, requests rejected %0d.",
               sb.allocs_ok, sb.frees_ok, sb.rejects);
      if (sb.errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
